@@ hdl/tpo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpo_pkg
// Shared constants and types for the triangle pair overlap test unit.
// ---------------------------------------------------------------------------
package tpo_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // Orientation sign: zero set for collinear, neg set for counterclockwise turn.
    typedef struct packed {
        logic neg;
        logic zero;
    } t_sign;

endpackage
`default_nettype wire

@@ hdl/tpo_orient.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpo_orient
// Three-stage exact orientation sign of the point triple p, q, r:
// differences, products, then subtract and classify.
// ---------------------------------------------------------------------------
module tpo_orient
    import tpo_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_px,
    input  logic signed [W-1:0] i_py,
    input  logic signed [W-1:0] i_qx,
    input  logic signed [W-1:0] i_qy,
    input  logic signed [W-1:0] i_rx,
    input  logic signed [W-1:0] i_ry,
    output t_sign               o_sign
);

    localparam int DW = W + 1;
    localparam int MW = 2 * DW;
    localparam int SW = MW + 1;

    logic signed [DW-1:0] r_d1, r_d2, r_d3, r_d4;
    logic signed [DW-1:0] n_d1, n_d2, n_d3, n_d4;
    logic signed [MW-1:0] r_m1, r_m2;
    logic signed [SW-1:0] n_diff;
    t_sign                r_sign, n_sign;

    always_comb begin
        n_d1 = DW'(i_qy) - DW'(i_py);
        n_d2 = DW'(i_rx) - DW'(i_qx);
        n_d3 = DW'(i_qx) - DW'(i_px);
        n_d4 = DW'(i_ry) - DW'(i_qy);
    end

    always_comb begin
        n_diff      = SW'(r_m1) - SW'(r_m2);
        n_sign.neg  = n_diff[SW-1];
        n_sign.zero = (n_diff == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1   <= n_d1;
            r_d2   <= n_d2;
            r_d3   <= n_d3;
            r_d4   <= n_d4;
            r_m1   <= MW'(r_d1) * MW'(r_d2);
            r_m2   <= MW'(r_d3) * MW'(r_d4);
            r_sign <= n_sign;
        end
    end

    assign o_sign = r_sign;

endmodule
`default_nettype wire

@@ hdl/triangle_pair_overlap_test_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// triangle_pair_overlap_test_unit
// Exact interior-overlap test for two 2D triangles with integer vertices.
// ---------------------------------------------------------------------------
//  channel  dir  contents
//  s_axis   in   twelve coordinates a1_x .. b3_y, COORD_WIDTH bits each
//  m_axis   out  overlap, first_degenerate, second_degenerate
//
//  One pair per cycle while m_axis is not stalled; the result register follows
//  the orientation lanes, whose stages are difference, product, subtract.
//  Twenty lanes run in parallel; the edge and inside tests form stage four.
//  A stall on m_axis freezes the whole pipeline; nothing is dropped.
//  Reset clears only the valid bits.
// ---------------------------------------------------------------------------
module triangle_pair_overlap_test_unit
    import tpo_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // a1_x, a1_y, a2_x, a2_y, a3_x, a3_y, b1_x, b1_y, b2_x, b2_y, b3_x, b3_y
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // overlap, first_degenerate, second_degenerate
    output logic [7:0]                               m_axis_tdata
);

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0] ax [3];
    logic signed [W-1:0] ay [3];
    logic signed [W-1:0] bx [3];
    logic signed [W-1:0] by [3];

    logic        en;
    logic        r_v1, r_v2, r_v3, r_v4;
    logic [8:0]  n_eq, r_eq1, r_eq2, r_eq3;
    t_sign       sa [3][3];
    t_sign       sb [3][3];
    t_sign       sda, sdb;
    logic        n_ovl, r_ovl, r_dega, r_degb;

    assign en            = !r_v4 || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ax[k] = s_axis_tdata[(2*k)*W +: W];
            ay[k] = s_axis_tdata[(2*k+1)*W +: W];
            bx[k] = s_axis_tdata[(6+2*k)*W +: W];
            by[k] = s_axis_tdata[(7+2*k)*W +: W];
        end
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_eq[i*3+k] = (ax[i] == bx[k]) && (ay[i] == by[k]);
            end
        end
    end

    // lane sa[i][k]: edge a_i -> a_i+1 against b_k; sb[j][k]: edge b_j -> b_j+1 against a_k
    for (genvar i = 0; i < 3; i++) begin : g_edge
        for (genvar k = 0; k < 3; k++) begin : g_pt
            tpo_orient #(.W(W)) u_oa (
                .i_clk (i_clk), .i_en (en),
                .i_px (ax[i]), .i_py (ay[i]),
                .i_qx (ax[(i+1)%3]), .i_qy (ay[(i+1)%3]),
                .i_rx (bx[k]), .i_ry (by[k]),
                .o_sign (sa[i][k])
            );
            tpo_orient #(.W(W)) u_ob (
                .i_clk (i_clk), .i_en (en),
                .i_px (bx[i]), .i_py (by[i]),
                .i_qx (bx[(i+1)%3]), .i_qy (by[(i+1)%3]),
                .i_rx (ax[k]), .i_ry (ay[k]),
                .o_sign (sb[i][k])
            );
        end
    end

    tpo_orient #(.W(W)) u_dega (
        .i_clk (i_clk), .i_en (en),
        .i_px (ax[0]), .i_py (ay[0]), .i_qx (ax[1]), .i_qy (ay[1]),
        .i_rx (ax[2]), .i_ry (ay[2]), .o_sign (sda)
    );
    tpo_orient #(.W(W)) u_degb (
        .i_clk (i_clk), .i_en (en),
        .i_px (bx[0]), .i_py (by[0]), .i_qx (bx[1]), .i_qy (by[1]),
        .i_rx (bx[2]), .i_ry (by[2]), .o_sign (sdb)
    );

    // Edge crossings and strict containment from the registered signs, masked when either triangle is degenerate.
    always_comb begin
        int ip, jp;
        logic shared, hit;
        hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ip = (i + 1) % 3;
                jp = (j + 1) % 3;
                shared = r_eq3[i*3+j] || r_eq3[i*3+jp] || r_eq3[ip*3+j] || r_eq3[ip*3+jp];
                if (!shared && !sa[i][j].zero && !sa[i][jp].zero
                        && !sb[j][i].zero && !sb[j][ip].zero
                        && (sa[i][j].neg != sa[i][jp].neg)
                        && (sb[j][i].neg != sb[j][ip].neg)) begin
                    hit = 1'b1;
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            // a_k inside b
            if (!(r_eq3[k*3] || r_eq3[k*3+1] || r_eq3[k*3+2])
                    && sb[0][k] == sb[1][k] && sb[0][k] == sb[2][k]) begin
                hit = 1'b1;
            end
            // b_k inside a
            if (!(r_eq3[k] || r_eq3[3+k] || r_eq3[6+k])
                    && sa[0][k] == sa[1][k] && sa[0][k] == sa[2][k]) begin
                hit = 1'b1;
            end
        end
        n_ovl = hit && !sda.zero && !sdb.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_eq1  <= n_eq;
            r_eq2  <= r_eq1;
            r_eq3  <= r_eq2;
            r_ovl  <= n_ovl;
            r_dega <= sda.zero;
            r_degb <= sdb.zero;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {5'b0, r_degb, r_dega, r_ovl};

`ifndef SYNTHESIS
    a_deg_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && (r_dega || r_degb) |-> !r_ovl)
        else $error("overlap reported for a degenerate triangle");

    a_sign_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> !(sda.neg && sda.zero) && !(sdb.neg && sdb.zero))
        else $error("orientation sign both negative and zero");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
